[hdl/ospf_dr_pkg.sv]
// Shared types and constants for the OSPF interface state machine and DR election.
// No dependencies.
`default_nettype none

package ospf_dr_pkg;

    localparam int NEIGHBORS = 16;
    localparam int IDX_W     = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int ID_W      = 32;
    localparam int PRIO_W    = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_PRIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IF_TYPE  = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_UP       = 3'd1,
        EV_WAIT_TMR = 3'd2,
        EV_BACKUP   = 3'd3,
        EV_NBR_CHG  = 3'd4,
        EV_LOOP     = 3'd5,
        EV_UNLOOP   = 3'd6,
        EV_DOWN     = 3'd7
    } ev_t;

    typedef enum logic [2:0] {
        IFS_DOWN   = 3'd0,
        IFS_LOOP   = 3'd1,
        IFS_WAIT   = 3'd2,
        IFS_PTP    = 3'd3,
        IFS_OTHER  = 3'd4,
        IFS_BACKUP = 3'd5,
        IFS_DR     = 3'd6
    } ifs_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_EXEC,
        SQ_FLAGS,
        SQ_SCAN_BDR,
        SQ_SCAN_DR,
        SQ_ROLE,
        SQ_DONE
    } seq_t;

endpackage

`default_nettype wire

[hdl/ospf_interface_fsm_dr_election.sv]
// OSPF interface state machine with neighbour table and DR/BDR election.
// Depends on ospf_dr_pkg.
//
// One request is taken at a time; in_stall is high from acceptance until the result is
// registered. A neighbour write or a non-electing event goes from the execute state
// straight to the done state. An electing event runs one or two election rounds on a
// single shared priority/id comparator that walks the neighbour table one entry per cycle,
// first for the BDR and then, if any neighbour declares itself DR, for the DR; each round
// passes through the flags, BDR scan, optional DR scan and role states. A finished result
// waits in the output register while the next request is accepted.
`default_nettype none

module ospf_interface_fsm_dr_election
    import ospf_dr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 op,
    input  wire logic [2:0]           event_req,
    input  wire logic [3:0]           nbr_index,
    input  wire logic                 nbr_valid,
    input  wire logic [ID_W-1:0]      nbr_id,
    input  wire logic [PRIO_W-1:0]    nbr_prio,
    input  wire logic                 nbr_two_way,
    input  wire logic [ID_W-1:0]      nbr_decl_dr,
    input  wire logic [ID_W-1:0]      nbr_decl_bdr,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [2:0]                iface_state,
    output logic [ID_W-1:0]           dr_id,
    output logic [ID_W-1:0]           bdr_id,
    output logic                      state_changed,
    output logic                      net_lsa_req,
    output logic                      hello_on,
    output logic                      wait_on,
    output logic                      kill_nbrs
);

    // configuration
    logic [ID_W-1:0]   own_id_reg;
    logic [PRIO_W-1:0] own_prio_reg;
    logic              if_type_reg;

    // captured request
    logic              in_op_reg;
    ev_t               in_ev_reg;
    logic [3:0]        in_idx_reg;
    logic              in_vld_reg;
    logic [ID_W-1:0]   in_id_reg;
    logic [PRIO_W-1:0] in_prio_reg;
    logic              in_tw_reg;
    logic [ID_W-1:0]   in_ddr_reg;
    logic [ID_W-1:0]   in_dbdr_reg;

    // interface state
    ifs_t              cur_state_reg;
    logic [ID_W-1:0]   cur_dr_reg;
    logic [ID_W-1:0]   cur_bdr_reg;

    // neighbour table
    logic [NEIGHBORS-1:0] tbl_valid_reg;
    logic [ID_W-1:0]      tbl_id_reg       [NEIGHBORS];
    logic [PRIO_W-1:0]    tbl_prio_reg     [NEIGHBORS];
    logic                 tbl_two_way_reg  [NEIGHBORS];
    logic [ID_W-1:0]      tbl_decl_dr_reg  [NEIGHBORS];
    logic [ID_W-1:0]      tbl_decl_bdr_reg [NEIGHBORS];

    // election
    logic [NEIGHBORS-1:0] elig_reg;
    logic [NEIGHBORS-1:0] dr_cand_reg;
    logic [NEIGHBORS-1:0] bdr_cand_reg;
    logic [NEIGHBORS-1:0] no_dr_reg;
    logic                 any_dr_reg;
    logic                 any_bdr_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic [ID_W-1:0]      best_id_reg;
    logic [PRIO_W-1:0]    best_prio_reg;
    logic                 have_reg;
    logic                 second_reg;

    // result
    ifs_t                 res_state_reg;
    logic                 res_kill_reg;

    // output register
    logic                 out_valid_reg;
    ifs_t                 out_state_reg;
    logic [ID_W-1:0]      out_dr_reg;
    logic [ID_W-1:0]      out_bdr_reg;
    logic                 out_chg_reg;
    logic                 out_net_reg;
    logic                 out_hello_reg;
    logic                 out_wait_reg;
    logic                 out_kill_reg;

    seq_t seq_reg, seq_next;

    // control strobes
    logic load_in;
    logic tbl_wr;
    logic clr_roles;
    logic res_we;
    ifs_t res_val;
    logic res_kill;
    logic flags_we;
    logic scan_we;
    logic decl_we;
    logic second_set;
    logic second_clr;
    logic load_out;

    // scan datapath
    logic             scan_last;
    logic             sel;
    logic             take;
    logic [ID_W-1:0]  pick_id;
    ifs_t             role;
    logic             rerun;
    logic [NEIGHBORS-1:0] elig_now;
    logic [NEIGHBORS-1:0] drc_now;
    logic [NEIGHBORS-1:0] bdrc_now;

    assign scan_last = (scan_idx_reg == IDX_W'(NEIGHBORS - 1));
    assign sel = (seq_reg == SQ_SCAN_BDR)
               ? (any_bdr_reg ? bdr_cand_reg[scan_idx_reg] : no_dr_reg[scan_idx_reg])
               : dr_cand_reg[scan_idx_reg];
    assign take = sel && (!have_reg ||
                  {tbl_prio_reg[scan_idx_reg], tbl_id_reg[scan_idx_reg]} >
                  {best_prio_reg, best_id_reg});
    assign pick_id = take ? tbl_id_reg[scan_idx_reg] : best_id_reg;

    assign role = (cur_dr_reg == own_id_reg)  ? IFS_DR :
                  (cur_bdr_reg == own_id_reg) ? IFS_BACKUP : IFS_OTHER;
    assign rerun = !second_reg && ((cur_state_reg < IFS_OTHER) || (role != cur_state_reg));

    always_comb
    begin
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            elig_now[i] = tbl_valid_reg[i] && (tbl_id_reg[i] != '0) &&
                          (tbl_prio_reg[i] != '0) && tbl_two_way_reg[i];
            drc_now[i]  = elig_now[i] && (tbl_id_reg[i] == tbl_decl_dr_reg[i]);
            bdrc_now[i] = elig_now[i] && !drc_now[i] &&
                          (tbl_id_reg[i] == tbl_decl_bdr_reg[i]);
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SQ_IDLE;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    always_comb
    begin
        seq_next   = seq_reg;
        in_stall   = 1'b1;
        load_in    = 1'b0;
        tbl_wr     = 1'b0;
        clr_roles  = 1'b0;
        res_we     = 1'b0;
        res_val    = cur_state_reg;
        res_kill   = 1'b0;
        flags_we   = 1'b0;
        scan_we    = 1'b0;
        decl_we    = 1'b0;
        second_set = 1'b0;
        second_clr = 1'b0;
        load_out   = 1'b0;
        case (seq_reg)
            SQ_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    load_in  = 1'b1;
                    seq_next = SQ_EXEC;
                end
            end
            SQ_EXEC:
            begin
                res_we   = 1'b1;
                seq_next = SQ_DONE;
                if (in_op_reg == OP_WRITE)
                begin
                    tbl_wr = 1'b1;
                end
                else
                begin
                    case (in_ev_reg)
                        EV_LOOP:
                        begin
                            res_val = IFS_LOOP;
                        end
                        EV_DOWN:
                        begin
                            if (cur_state_reg != IFS_DOWN)
                            begin
                                res_val   = IFS_DOWN;
                                res_kill  = 1'b1;
                                clr_roles = 1'b1;
                            end
                        end
                        EV_UP:
                        begin
                            if (cur_state_reg == IFS_DOWN)
                            begin
                                if (if_type_reg)
                                    res_val = IFS_PTP;
                                else if (own_prio_reg == '0)
                                    res_val = IFS_OTHER;
                                else
                                    res_val = IFS_WAIT;
                            end
                        end
                        EV_UNLOOP:
                        begin
                            if (cur_state_reg == IFS_LOOP)
                                res_val = IFS_DOWN;
                        end
                        EV_WAIT_TMR, EV_BACKUP:
                        begin
                            if (cur_state_reg == IFS_WAIT)
                            begin
                                res_we     = 1'b0;
                                second_clr = 1'b1;
                                seq_next   = SQ_FLAGS;
                            end
                        end
                        EV_NBR_CHG:
                        begin
                            if (cur_state_reg >= IFS_OTHER && cur_state_reg <= IFS_DR)
                            begin
                                res_we     = 1'b0;
                                second_clr = 1'b1;
                                seq_next   = SQ_FLAGS;
                            end
                        end
                        default:
                        begin
                            res_val = cur_state_reg;
                        end
                    endcase
                end
            end
            SQ_FLAGS:
            begin
                flags_we = 1'b1;
                seq_next = SQ_SCAN_BDR;
            end
            SQ_SCAN_BDR:
            begin
                scan_we = 1'b1;
                if (scan_last)
                    seq_next = any_dr_reg ? SQ_SCAN_DR : SQ_ROLE;
            end
            SQ_SCAN_DR:
            begin
                scan_we = 1'b1;
                if (scan_last)
                    seq_next = SQ_ROLE;
            end
            SQ_ROLE:
            begin
                decl_we = rerun || second_reg;
                if (rerun)
                begin
                    second_set = 1'b1;
                    seq_next   = SQ_FLAGS;
                end
                else
                begin
                    res_we   = 1'b1;
                    res_val  = role;
                    seq_next = SQ_DONE;
                end
            end
            SQ_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out = 1'b1;
                    seq_next = SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= '0;
            own_prio_reg <= PRIO_W'(1);
            if_type_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ID:   own_id_reg   <= cfg_data[ID_W-1:0];
                CFG_OWN_PRIO: own_prio_reg <= cfg_data[PRIO_W-1:0];
                CFG_IF_TYPE:  if_type_reg  <= cfg_data[0];
                default:      own_id_reg   <= own_id_reg;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_op_reg   <= op;
            in_ev_reg   <= ev_t'(event_req);
            in_idx_reg  <= nbr_index;
            in_vld_reg  <= nbr_valid;
            in_id_reg   <= nbr_id;
            in_prio_reg <= nbr_prio;
            in_tw_reg   <= nbr_two_way;
            in_ddr_reg  <= nbr_decl_dr;
            in_dbdr_reg <= nbr_decl_bdr;
        end
    end

    // neighbour table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
        end
        else if (tbl_wr && (int'(in_idx_reg) < NEIGHBORS))
        begin
            tbl_valid_reg[IDX_W'(in_idx_reg)] <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr && (int'(in_idx_reg) < NEIGHBORS))
        begin
            tbl_id_reg[IDX_W'(in_idx_reg)]       <= in_id_reg;
            tbl_prio_reg[IDX_W'(in_idx_reg)]     <= in_prio_reg;
            tbl_two_way_reg[IDX_W'(in_idx_reg)]  <= in_tw_reg;
            tbl_decl_dr_reg[IDX_W'(in_idx_reg)]  <= in_ddr_reg;
            tbl_decl_bdr_reg[IDX_W'(in_idx_reg)] <= in_dbdr_reg;
        end
        else if (decl_we)
        begin
            for (int i = 0; i < NEIGHBORS; i++)
            begin
                if (elig_reg[i] && (tbl_id_reg[i] == own_id_reg))
                begin
                    tbl_decl_dr_reg[i]  <= cur_dr_reg;
                    tbl_decl_bdr_reg[i] <= cur_bdr_reg;
                end
            end
        end
    end

    // election scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            have_reg     <= 1'b0;
            second_reg   <= 1'b0;
        end
        else
        begin
            if (second_clr)
                second_reg <= 1'b0;
            else if (second_set)
                second_reg <= 1'b1;
            if (flags_we)
            begin
                scan_idx_reg <= '0;
                have_reg     <= 1'b0;
            end
            else if (scan_we)
            begin
                scan_idx_reg <= scan_last ? '0 : scan_idx_reg + IDX_W'(1);
                have_reg     <= scan_last ? 1'b0 : (have_reg || take);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (flags_we)
        begin
            elig_reg     <= elig_now;
            dr_cand_reg  <= drc_now;
            bdr_cand_reg <= bdrc_now;
            no_dr_reg    <= elig_now & ~drc_now;
            any_dr_reg   <= |drc_now;
            any_bdr_reg  <= |bdrc_now;
            best_id_reg  <= '0;
            best_prio_reg <= '0;
        end
        else if (scan_we)
        begin
            if (scan_last)
            begin
                best_id_reg   <= '0;
                best_prio_reg <= '0;
            end
            else if (take)
            begin
                best_id_reg   <= tbl_id_reg[scan_idx_reg];
                best_prio_reg <= tbl_prio_reg[scan_idx_reg];
            end
        end
    end

    // interface state, DR and BDR
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg <= IFS_DOWN;
            cur_dr_reg    <= '0;
            cur_bdr_reg   <= '0;
        end
        else
        begin
            if (clr_roles)
            begin
                cur_dr_reg  <= '0;
                cur_bdr_reg <= '0;
            end
            else if (scan_we && scan_last)
            begin
                if (seq_reg == SQ_SCAN_BDR)
                begin
                    cur_bdr_reg <= pick_id;
                    if (!any_dr_reg)
                        cur_dr_reg <= pick_id;
                end
                else
                begin
                    cur_dr_reg <= pick_id;
                end
            end
            if (load_out)
                cur_state_reg <= res_state_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_state_reg <= res_val;
            res_kill_reg  <= res_kill;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_state_reg <= res_state_reg;
            out_dr_reg    <= cur_dr_reg;
            out_bdr_reg   <= cur_bdr_reg;
            out_chg_reg   <= (res_state_reg != cur_state_reg);
            out_net_reg   <= (res_state_reg != cur_state_reg) && (res_state_reg == IFS_DR);
            out_hello_reg <= (res_state_reg >= IFS_WAIT) && (res_state_reg <= IFS_DR);
            out_wait_reg  <= (res_state_reg == IFS_WAIT);
            out_kill_reg  <= res_kill_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign iface_state   = out_state_reg;
    assign dr_id         = out_dr_reg;
    assign bdr_id        = out_bdr_reg;
    assign state_changed = out_chg_reg;
    assign net_lsa_req   = out_net_reg;
    assign hello_on      = out_hello_reg;
    assign wait_on       = out_wait_reg;
    assign kill_nbrs     = out_kill_reg;

`ifndef SYNTHESIS
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SQ_IDLE && !in_valid) |=> (seq_reg == SQ_IDLE))
        else $error("sequencer left idle without a request");

    a_net_lsa_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(net_lsa_req && !state_changed))
        else $error("network LSA flagged without a state change");

    a_kill_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kill_nbrs) |->
            (iface_state == IFS_DOWN && dr_id == '0 && bdr_id == '0))
        else $error("neighbour kill without down state and cleared roles");

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote a stalled output");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SQ_FLAGS) |=> (seq_reg == SQ_SCAN_BDR && scan_idx_reg == '0))
        else $error("election scan did not start at the first entry");
`endif

endmodule

`default_nettype wire

[bench/ospf_interface_fsm_dr_election_test.sv]
// Self-checking bench for ospf_interface_fsm_dr_election: random neighbour writes and
// interface events with bursty requests and a stalling receiver, checked against a predictor.
// Depends on ospf_dr_pkg and the block itself.
`timescale 1ns / 100ps

module ospf_interface_fsm_dr_election_test;
    import ospf_dr_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 80;
    localparam int PHASE_ITEMS   = 245;

    typedef struct {
        logic              op;
        ev_t               ev;
        logic [3:0]        slot;
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              two_way;
        logic [ID_W-1:0]   decl_dr;
        logic [ID_W-1:0]   decl_bdr;
    } nbr_req_t;

    typedef struct {
        ifs_t            state;
        logic [ID_W-1:0] dr;
        logic [ID_W-1:0] bdr;
        logic            changed;
        logic            net_lsa;
        logic            hello;
        logic            waiting;
        logic            kill;
    } iface_report_t;

    class dr_election_scoreboard;
        logic [ID_W-1:0]   own_id;
        logic [PRIO_W-1:0] own_prio;
        logic              ptp_type;
        ifs_t              state;
        logic [ID_W-1:0]   dr;
        logic [ID_W-1:0]   bdr;
        logic              slot_valid    [NEIGHBORS];
        logic [ID_W-1:0]   slot_id       [NEIGHBORS];
        logic [PRIO_W-1:0] slot_prio     [NEIGHBORS];
        logic              slot_two_way  [NEIGHBORS];
        logic [ID_W-1:0]   slot_decl_dr  [NEIGHBORS];
        logic [ID_W-1:0]   slot_decl_bdr [NEIGHBORS];
        iface_report_t     expected_reports[$];
        int                errors;

        function new();
            own_id   = '0;
            own_prio = 8'd1;
            ptp_type = 1'b0;
            state    = IFS_DOWN;
            dr       = '0;
            bdr      = '0;
            errors   = 0;
            for (int i = 0; i < NEIGHBORS; i++)
            begin
                slot_valid[i]    = 1'b0;
                slot_id[i]       = '0;
                slot_prio[i]     = '0;
                slot_two_way[i]  = 1'b0;
                slot_decl_dr[i]  = '0;
                slot_decl_bdr[i] = '0;
            end
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_OWN_ID:   own_id   = data[ID_W-1:0];
                CFG_OWN_PRIO: own_prio = data[PRIO_W-1:0];
                CFG_IF_TYPE:  ptp_type = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // highest priority, then highest id
        function logic [ID_W-1:0] best_of(logic [NEIGHBORS-1:0] sel);
            logic [ID_W-1:0]   best_id;
            logic [PRIO_W-1:0] best_prio;
            logic              have;
            best_id   = '0;
            best_prio = '0;
            have      = 1'b0;
            for (int i = 0; i < NEIGHBORS; i++)
            begin
                if (sel[i] && (!have || slot_prio[i] > best_prio ||
                    (slot_prio[i] == best_prio && slot_id[i] > best_id)))
                begin
                    best_id   = slot_id[i];
                    best_prio = slot_prio[i];
                    have      = 1'b1;
                end
            end
            return best_id;
        endfunction

        function void elect_pair(logic [NEIGHBORS-1:0] elig);
            logic [NEIGHBORS-1:0] dr_cand;
            logic [NEIGHBORS-1:0] no_dr;
            logic [NEIGHBORS-1:0] bdr_cand;
            dr_cand  = '0;
            no_dr    = '0;
            bdr_cand = '0;
            for (int i = 0; i < NEIGHBORS; i++)
            begin
                if (elig[i])
                begin
                    if (slot_id[i] == slot_decl_dr[i])
                        dr_cand[i] = 1'b1;
                    else
                    begin
                        no_dr[i] = 1'b1;
                        if (slot_id[i] == slot_decl_bdr[i])
                            bdr_cand[i] = 1'b1;
                    end
                end
            end
            bdr = (bdr_cand != '0) ? best_of(bdr_cand) : best_of(no_dr);
            dr  = (dr_cand != '0) ? best_of(dr_cand) : bdr;
        endfunction

        function ifs_t role_of();
            if (dr == own_id)
                return IFS_DR;
            if (bdr == own_id)
                return IFS_BACKUP;
            return IFS_OTHER;
        endfunction

        function void declare_self(logic [NEIGHBORS-1:0] elig);
            for (int i = 0; i < NEIGHBORS; i++)
            begin
                if (elig[i] && slot_id[i] == own_id)
                begin
                    slot_decl_dr[i]  = dr;
                    slot_decl_bdr[i] = bdr;
                end
            end
        endfunction

        function ifs_t run_election(ifs_t prior);
            logic [NEIGHBORS-1:0] elig;
            ifs_t                 role;
            for (int i = 0; i < NEIGHBORS; i++)
                elig[i] = slot_valid[i] && slot_id[i] != '0 && slot_prio[i] != '0 &&
                          slot_two_way[i];
            elect_pair(elig);
            role = role_of();
            // second pass once our own declarations follow the result
            if (prior < IFS_OTHER || role != prior)
            begin
                declare_self(elig);
                elect_pair(elig);
                role = role_of();
                declare_self(elig);
            end
            return role;
        endfunction

        function void note_request(nbr_req_t r);
            ifs_t          prior;
            ifs_t          after_state;
            logic          kill;
            iface_report_t want;
            prior       = state;
            after_state = state;
            kill        = 1'b0;
            if (r.op == OP_WRITE)
            begin
                if (r.slot < NEIGHBORS)
                begin
                    slot_valid[r.slot]    = r.valid;
                    slot_id[r.slot]       = r.id;
                    slot_prio[r.slot]     = r.prio;
                    slot_two_way[r.slot]  = r.two_way;
                    slot_decl_dr[r.slot]  = r.decl_dr;
                    slot_decl_bdr[r.slot] = r.decl_bdr;
                end
            end
            else
            begin
                case (r.ev)
                    EV_LOOP:
                        after_state = IFS_LOOP;
                    EV_DOWN:
                        if (prior != IFS_DOWN)
                        begin
                            after_state = IFS_DOWN;
                            dr          = '0;
                            bdr         = '0;
                            kill        = 1'b1;
                        end
                    EV_UP:
                        if (prior == IFS_DOWN)
                        begin
                            if (ptp_type)
                                after_state = IFS_PTP;
                            else if (own_prio == '0)
                                after_state = IFS_OTHER;
                            else
                                after_state = IFS_WAIT;
                        end
                    EV_UNLOOP:
                        if (prior == IFS_LOOP)
                            after_state = IFS_DOWN;
                    EV_WAIT_TMR, EV_BACKUP:
                        if (prior == IFS_WAIT)
                            after_state = run_election(prior);
                    EV_NBR_CHG:
                        if (prior inside {IFS_OTHER, IFS_BACKUP, IFS_DR})
                            after_state = run_election(prior);
                    default: ;
                endcase
            end
            state        = after_state;
            want.state   = after_state;
            want.dr      = dr;
            want.bdr     = bdr;
            want.changed = after_state != prior;
            want.net_lsa = after_state != prior && after_state == IFS_DR;
            want.hello   = after_state inside {IFS_WAIT, IFS_PTP, IFS_OTHER, IFS_BACKUP, IFS_DR};
            want.waiting = after_state == IFS_WAIT;
            want.kill    = kill;
            expected_reports.push_back(want);
        endfunction

        function void compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(iface_report_t got);
            iface_report_t want;
            if (expected_reports.size() == 0)
            begin
                $error("result with no request outstanding, iface_state %0d", got.state);
                errors++;
            end
            else
            begin
                want = expected_reports.pop_front();
                compare_field("iface_state", ID_W'(want.state), ID_W'(got.state));
                compare_field("dr_id", want.dr, got.dr);
                compare_field("bdr_id", want.bdr, got.bdr);
                compare_field("state_changed", ID_W'(want.changed), ID_W'(got.changed));
                compare_field("net_lsa_req", ID_W'(want.net_lsa), ID_W'(got.net_lsa));
                compare_field("hello_on", ID_W'(want.hello), ID_W'(got.hello));
                compare_field("wait_on", ID_W'(want.waiting), ID_W'(got.waiting));
                compare_field("kill_nbrs", ID_W'(want.kill), ID_W'(got.kill));
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 op = OP_WRITE;
    logic [2:0]           event_req = EV_NONE;
    logic [3:0]           nbr_index = '0;
    logic                 nbr_valid = 1'b0;
    logic [ID_W-1:0]      nbr_id = '0;
    logic [PRIO_W-1:0]    nbr_prio = '0;
    logic                 nbr_two_way = 1'b0;
    logic [ID_W-1:0]      nbr_decl_dr = '0;
    logic [ID_W-1:0]      nbr_decl_bdr = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           iface_state;
    logic [ID_W-1:0]      dr_id;
    logic [ID_W-1:0]      bdr_id;
    logic                 state_changed;
    logic                 net_lsa_req;
    logic                 hello_on;
    logic                 wait_on;
    logic                 kill_nbrs;

    dr_election_scoreboard sb;
    int burst_left = 0;
    int seg_left = 0;
    int seg_kind = 0;
    int idle_cycles = 0;

    ospf_interface_fsm_dr_election dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .event_req     (event_req),
        .nbr_index     (nbr_index),
        .nbr_valid     (nbr_valid),
        .nbr_id        (nbr_id),
        .nbr_prio      (nbr_prio),
        .nbr_two_way   (nbr_two_way),
        .nbr_decl_dr   (nbr_decl_dr),
        .nbr_decl_bdr  (nbr_decl_bdr),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .iface_state   (iface_state),
        .dr_id         (dr_id),
        .bdr_id        (bdr_id),
        .state_changed (state_changed),
        .net_lsa_req   (net_lsa_req),
        .hello_on      (hello_on),
        .wait_on       (wait_on),
        .kill_nbrs     (kill_nbrs)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // receiver: segments of no stall, random stall, long stall runs and a periodic stall
    always @(posedge clk)
    begin
        if (seg_left == 0)
        begin
            seg_kind = $urandom_range(0, 3);
            seg_left = $urandom_range(8, 60);
        end
        else
            seg_left--;
        case (seg_kind)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= (seg_left % 16) < 12;
            default: out_stall <= (seg_left % 3) == 0;
        endcase
    end

    always @(posedge clk)
    begin : monitor
        nbr_req_t      seen;
        iface_report_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen.op       = op;
                seen.ev       = ev_t'(event_req);
                seen.slot     = nbr_index;
                seen.valid    = nbr_valid;
                seen.id       = nbr_id;
                seen.prio     = nbr_prio;
                seen.two_way  = nbr_two_way;
                seen.decl_dr  = nbr_decl_dr;
                seen.decl_bdr = nbr_decl_bdr;
                sb.note_request(seen);
            end
            if (out_valid && !out_stall)
            begin
                got.state   = ifs_t'(iface_state);
                got.dr      = dr_id;
                got.bdr     = bdr_id;
                got.changed = state_changed;
                got.net_lsa = net_lsa_req;
                got.hello   = hello_on;
                got.waiting = wait_on;
                got.kill    = kill_nbrs;
                sb.check_result(got);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ospf_interface_fsm_dr_election_test: done, errors");
                $finish;
            end
        end
    end

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 19))
            0, 1, 2, 3: return sb.own_id;
            14, 15, 16: return $urandom();
            17:         return '0;
            18, 19:     return '1;
            default:    return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_decl(logic [ID_W-1:0] self_id);
        case ($urandom_range(0, 9))
            0, 1, 2: return self_id;
            3, 4:    return sb.own_id;
            5, 6:    return pick_id();
            default: return $urandom();
        endcase
    endfunction

    function automatic nbr_req_t random_request();
        nbr_req_t r;
        r.op = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_EVENT;
        case ($urandom_range(0, 17))
            0:                      r.ev = EV_NONE;
            1, 2, 3:                r.ev = EV_UP;
            4, 5, 6:                r.ev = EV_WAIT_TMR;
            7, 8:                   r.ev = EV_BACKUP;
            9, 10, 11, 12, 13, 14:  r.ev = EV_NBR_CHG;
            15:                     r.ev = EV_LOOP;
            16:                     r.ev = EV_UNLOOP;
            default:                r.ev = EV_DOWN;
        endcase
        r.slot  = 4'($urandom_range(0, 15));
        r.valid = $urandom_range(0, 7) != 0;
        r.id    = pick_id();
        case ($urandom_range(0, 9))
            0:       r.prio = '0;
            1:       r.prio = '1;
            2, 3:    r.prio = PRIO_W'($urandom_range(0, 255));
            default: r.prio = PRIO_W'($urandom_range(1, 3));
        endcase
        r.two_way  = $urandom_range(0, 7) != 0;
        r.decl_dr  = pick_decl(r.id);
        r.decl_bdr = pick_decl(r.id);
        return r;
    endfunction

    task automatic send_request(nbr_req_t r);
        int gap;
        in_valid     <= 1'b1;
        op           <= r.op;
        event_req    <= r.ev;
        nbr_index    <= r.slot;
        nbr_valid    <= r.valid;
        nbr_id       <= r.id;
        nbr_prio     <= r.prio;
        nbr_two_way  <= r.two_way;
        nbr_decl_dr  <= r.decl_dr;
        nbr_decl_bdr <= r.decl_bdr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic send_event(ev_t e);
        nbr_req_t r;
        r    = random_request();
        r.op = OP_EVENT;
        r.ev = e;
        send_request(r);
    endtask

    task automatic send_write(logic [3:0] slot, logic valid, logic [ID_W-1:0] id,
                              logic [PRIO_W-1:0] prio, logic two_way,
                              logic [ID_W-1:0] decl_dr, logic [ID_W-1:0] decl_bdr);
        nbr_req_t r;
        r          = random_request();
        r.op       = OP_WRITE;
        r.slot     = slot;
        r.valid    = valid;
        r.id       = id;
        r.prio     = prio;
        r.two_way  = two_way;
        r.decl_dr  = decl_dr;
        r.decl_bdr = decl_bdr;
        send_request(r);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_config(idx, data);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: own id zero, priority one, broadcast
        send_event(EV_NONE);
        send_event(EV_DOWN);
        send_event(EV_UNLOOP);
        send_event(EV_NBR_CHG);
        send_write(4'd0, 1'b1, '1, '1, 1'b1, '1, '0);
        send_write(4'd15, 1'b1, 32'd1, 8'd1, 1'b1, '0, 32'd1);
        send_write(4'd7, 1'b1, '0, '1, 1'b1, '0, '0);
        send_write(4'd3, 1'b0, 32'd5, 8'd9, 1'b1, 32'd5, 32'd5);
        send_write(4'd9, 1'b1, 32'd2, '1, 1'b0, 32'd2, 32'd2);
        send_event(EV_UP);
        send_event(EV_NBR_CHG);
        send_event(EV_UP);
        send_event(EV_WAIT_TMR);
        send_event(EV_NBR_CHG);
        send_write(4'd0, 1'b0, '0, '0, 1'b0, '0, '0);
        send_write(4'd15, 1'b0, '0, '0, 1'b0, '0, '0);
        // nobody eligible and own id zero: we become DR
        send_event(EV_NBR_CHG);
        send_event(EV_BACKUP);
        send_event(EV_LOOP);
        send_event(EV_NBR_CHG);
        send_event(EV_UNLOOP);
        send_event(EV_LOOP);
        send_event(EV_DOWN);
        send_event(EV_UP);
        send_event(EV_BACKUP);
        in_valid <= 1'b0;

        for (int phase = 0; phase < 5; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    write_cfg(CFG_OWN_ID, 32'd1);
                    write_cfg(CFG_OWN_PRIO, 32'd1);
                    write_cfg(CFG_IF_TYPE, 32'd0);
                end
                1:
                begin
                    write_cfg(CFG_OWN_ID, 32'd0);
                    write_cfg(CFG_OWN_PRIO, 32'd0);
                end
                2:
                begin
                    write_cfg(CFG_OWN_ID, 32'hFFFF_FFFF);
                    write_cfg(CFG_OWN_PRIO, 32'd255);
                    write_cfg(CFG_IF_TYPE, 32'd1);
                end
                3:
                begin
                    write_cfg(CFG_OWN_ID, $urandom_range(2, 8));
                    write_cfg(CFG_OWN_PRIO, $urandom_range(1, 254));
                    write_cfg(CFG_IF_TYPE, 32'd0);
                end
                default:
                begin
                    write_cfg(CFG_OWN_ID, $urandom());
                    write_cfg(CFG_OWN_PRIO, $urandom_range(0, 255));
                    write_cfg(CFG_IF_TYPE, $urandom_range(0, 1));
                end
            endcase
            cfg_we <= 1'b0;
            repeat (PHASE_ITEMS) send_request(random_request());
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ospf_interface_fsm_dr_election_test: done, clean");
        else
            $display("ospf_interface_fsm_dr_election_test: done, errors");
        $finish;
    end

endmodule

[sim.f]
hdl/ospf_dr_pkg.sv
hdl/ospf_interface_fsm_dr_election.sv
bench/ospf_interface_fsm_dr_election_test.sv
